FILE: design/vntc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package vntc_pkg;

    // Lattice neighborhood: rows u-1 .. u+2, columns v-1 .. v+2
    localparam int unsigned GRID_N = 4;

    typedef logic [GRID_N-1:0][GRID_N-1:0][7:0] t_grid;

    typedef struct packed {
        logic [7:0] u;
        logic [7:0] v;
    } t_coord;

    // Register indexes on the configuration port
    localparam logic [2:0] REG_SEED  = 3'd0;
    localparam logic [2:0] REG_SCALE = 3'd1;
    localparam logic [2:0] REG_WATER = 3'd2;
    localparam logic [2:0] REG_GRASS = 3'd3;
    localparam logic [2:0] REG_TREE  = 3'd4;

    // Tile codes
    localparam logic [1:0] TILE_GRASS = 2'd0;
    localparam logic [1:0] TILE_WATER = 2'd1;
    localparam logic [1:0] TILE_TREES = 2'd2;
    localparam logic [1:0] TILE_MOUNT = 2'd3;

    localparam logic [7:0] SEED_RESET  = 8'd1;
    localparam logic [7:0] SCALE_RESET = 8'd1;
    localparam logic [7:0] WATER_RESET = 8'd100;
    localparam logic [7:0] GRASS_RESET = 8'd135;
    localparam logic [7:0] TREE_RESET  = 8'd160;

    // Largest smoothed value: 4*255>>4 + 4*255>>3 + 255>>2
    localparam logic [7:0] LEVEL_MAX = 8'd253;

endpackage

`default_nettype wire

FILE: design/vntc_div_pipe.sv
`timescale 1ns / 1ps
`default_nettype none

module vntc_div_pipe (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic [7:0]        i_num_x,
    input  wire logic [7:0]        i_num_y,
    input  wire logic [7:0]        i_den,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output vntc_pkg::t_coord       o_quo
);

    localparam int unsigned STAGES = 8;

    logic       r_valid [STAGES];
    logic [7:0] r_rem_x [STAGES];
    logic [7:0] r_rem_y [STAGES];
    logic [7:0] r_num_x [STAGES];
    logic [7:0] r_num_y [STAGES];
    logic [7:0] r_quo_x [STAGES];
    logic [7:0] r_quo_y [STAGES];
    logic [7:0] r_den   [STAGES];
    logic       w_ready [STAGES+1];

    // Restoring step: returns {quotient bit, new remainder}.
    // A zero divisor sets every quotient bit, giving 255.
    function automatic logic [8:0] div_step(input logic [7:0] rem, input logic bit_in,
                                            input logic [7:0] den);
        logic [8:0] t;
        logic [8:0] diff;
        logic       ge;
        t    = {rem, bit_in};
        diff = t - {1'b0, den};
        ge   = (t >= {1'b0, den});
        return {ge, (ge ? diff[7:0] : t[7:0])};
    endfunction

    assign w_ready[STAGES] = i_ready;

    for (genvar s = 0; s < STAGES; s++) begin : g_stage
        logic       w_pv;
        logic [7:0] w_prem_x, w_prem_y, w_pnum_x, w_pnum_y, w_pquo_x, w_pquo_y, w_pden;
        logic [8:0] w_step_x, w_step_y;

        if (s == 0) begin : g_first
            assign w_pv     = i_valid;
            assign w_prem_x = '0;
            assign w_prem_y = '0;
            assign w_pnum_x = i_num_x;
            assign w_pnum_y = i_num_y;
            assign w_pquo_x = '0;
            assign w_pquo_y = '0;
            assign w_pden   = i_den;
        end else begin : g_next
            assign w_pv     = r_valid[s-1];
            assign w_prem_x = r_rem_x[s-1];
            assign w_prem_y = r_rem_y[s-1];
            assign w_pnum_x = r_num_x[s-1];
            assign w_pnum_y = r_num_y[s-1];
            assign w_pquo_x = r_quo_x[s-1];
            assign w_pquo_y = r_quo_y[s-1];
            assign w_pden   = r_den[s-1];
        end

        assign w_step_x   = div_step(w_prem_x, w_pnum_x[7], w_pden);
        assign w_step_y   = div_step(w_prem_y, w_pnum_y[7], w_pden);
        assign w_ready[s] = !r_valid[s] || w_ready[s+1];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[s] <= 1'b0;
            end else if (w_ready[s]) begin
                r_valid[s] <= w_pv;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_ready[s] && w_pv) begin
                r_rem_x[s] <= w_step_x[7:0];
                r_rem_y[s] <= w_step_y[7:0];
                r_num_x[s] <= {w_pnum_x[6:0], 1'b0};
                r_num_y[s] <= {w_pnum_y[6:0], 1'b0};
                r_quo_x[s] <= {w_pquo_x[6:0], w_step_x[8]};
                r_quo_y[s] <= {w_pquo_y[6:0], w_step_y[8]};
                r_den[s]   <= w_pden;
            end
        end
    end

    assign o_ready = w_ready[0];
    assign o_valid = r_valid[STAGES-1];
    assign o_quo   = '{u: r_quo_x[STAGES-1], v: r_quo_y[STAGES-1]};

`ifndef ASSERT_OFF
    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid[STAGES-1] && r_den[STAGES-1] != 8'd0) |->
        (r_rem_x[STAGES-1] < r_den[STAGES-1] && r_rem_y[STAGES-1] < r_den[STAGES-1]))
        else $error("divider remainder not below divisor");

    a_zero_den_saturates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid[STAGES-1] && r_den[STAGES-1] == 8'd0) |->
        (r_quo_x[STAGES-1] == 8'hFF && r_quo_y[STAGES-1] == 8'hFF))
        else $error("zero divisor did not give all-ones quotient");
`endif

endmodule

`default_nettype wire

FILE: design/vntc_hash.sv
`timescale 1ns / 1ps
`default_nettype none

module vntc_hash (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire vntc_pkg::t_coord  i_coord,
    input  wire logic [7:0]        i_seed,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output vntc_pkg::t_grid        o_grid
);

    logic            r_valid_a;
    vntc_pkg::t_grid r_p_a;
    vntc_pkg::t_grid r_q_a;
    vntc_pkg::t_grid n_p_a;
    vntc_pkg::t_grid n_q_a;
    logic            r_valid_b;
    vntc_pkg::t_grid r_grid_b;
    vntc_pkg::t_grid n_grid_b;
    logic            w_ready_a;
    logic            w_ready_b;

    assign w_ready_b = !r_valid_b || i_ready;
    assign w_ready_a = !r_valid_a || w_ready_b;

    // Xor-shift mixing of each lattice point of the 4x4 neighborhood
    always_comb begin
        logic [7:0] a, b, p, q;
        for (int i = 0; i < vntc_pkg::GRID_N; i++) begin
            for (int j = 0; j < vntc_pkg::GRID_N; j++) begin
                a = i_coord.u + 8'(i) - 8'd1;
                b = i_coord.v + 8'(j) - 8'd1;
                p = a ^ {b[0], 7'b0};
                p = p ^ (p >> 5);
                q = b ^ {p[4:0], 3'b0};
                q = q ^ (q >> 1);
                n_p_a[i][j] = p;
                n_q_a[i][j] = q;
            end
        end
    end

    // Seed product, low byte only
    always_comb begin
        logic [15:0] prod;
        for (int i = 0; i < vntc_pkg::GRID_N; i++) begin
            for (int j = 0; j < vntc_pkg::GRID_N; j++) begin
                prod           = {8'd0, r_q_a[i][j]} * {8'd0, i_seed};
                n_grid_b[i][j] = r_p_a[i][j] ^ prod[7:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_a <= 1'b0;
            r_valid_b <= 1'b0;
        end else begin
            if (w_ready_a) begin
                r_valid_a <= i_valid;
            end
            if (w_ready_b) begin
                r_valid_b <= r_valid_a;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ready_a && i_valid) begin
            r_p_a <= n_p_a;
            r_q_a <= n_q_a;
        end
        if (w_ready_b && r_valid_a) begin
            r_grid_b <= n_grid_b;
        end
    end

    assign o_ready = w_ready_a;
    assign o_valid = r_valid_b;
    assign o_grid  = r_grid_b;

endmodule

`default_nettype wire

FILE: design/vntc_smooth.sv
`timescale 1ns / 1ps
`default_nettype none

module vntc_smooth (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire vntc_pkg::t_grid   i_grid,
    input  wire logic [7:0]        i_water_limit,
    input  wire logic [7:0]        i_grass_limit,
    input  wire logic [7:0]        i_tree_limit,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output logic [1:0]             o_tile_code,
    output logic [7:0]             o_noise_level
);

    logic                 r_valid_c;
    logic [1:0][1:0][7:0] r_smooth_c;
    logic [1:0][1:0][7:0] n_smooth_c;
    logic                 r_valid_d;
    logic [7:0]           r_level_d;
    logic [7:0]           n_level_d;
    logic                 r_valid_e;
    logic [7:0]           r_level_e;
    logic [1:0]           r_tile_e;
    logic [1:0]           n_tile_e;
    logic                 w_ready_c;
    logic                 w_ready_d;
    logic                 w_ready_e;

    assign w_ready_e = !r_valid_e || i_ready;
    assign w_ready_d = !r_valid_d || w_ready_e;
    assign w_ready_c = !r_valid_c || w_ready_d;

    // 3x3 weighted smoothing at (u,v), (u+1,v), (u,v+1), (u+1,v+1)
    always_comb begin
        logic [9:0] cs, ss;
        for (int di = 0; di < 2; di++) begin
            for (int dj = 0; dj < 2; dj++) begin
                cs = 10'(i_grid[di][dj]) + 10'(i_grid[di+2][dj])
                   + 10'(i_grid[di][dj+2]) + 10'(i_grid[di+2][dj+2]);
                ss = 10'(i_grid[di][dj+1]) + 10'(i_grid[di+2][dj+1])
                   + 10'(i_grid[di+1][dj]) + 10'(i_grid[di+1][dj+2]);
                n_smooth_c[di][dj] = 8'(cs >> 4) + 8'(ss >> 3)
                                   + (i_grid[di+1][dj+1] >> 2);
            end
        end
    end

    // Average along x, then the two rows
    always_comb begin
        logic [8:0] sum0, sum1, sum2;
        sum0      = {1'b0, r_smooth_c[0][0]} + {1'b0, r_smooth_c[1][0]};
        sum1      = {1'b0, r_smooth_c[0][1]} + {1'b0, r_smooth_c[1][1]};
        sum2      = {1'b0, sum0[8:1]} + {1'b0, sum1[8:1]};
        n_level_d = sum2[8:1];
    end

    // First limit that holds decides
    always_comb begin
        if (r_level_d < i_water_limit) begin
            n_tile_e = vntc_pkg::TILE_WATER;
        end else if (r_level_d < i_grass_limit) begin
            n_tile_e = vntc_pkg::TILE_GRASS;
        end else if (r_level_d < i_tree_limit) begin
            n_tile_e = vntc_pkg::TILE_TREES;
        end else begin
            n_tile_e = vntc_pkg::TILE_MOUNT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_c <= 1'b0;
            r_valid_d <= 1'b0;
            r_valid_e <= 1'b0;
        end else begin
            if (w_ready_c) begin
                r_valid_c <= i_valid;
            end
            if (w_ready_d) begin
                r_valid_d <= r_valid_c;
            end
            if (w_ready_e) begin
                r_valid_e <= r_valid_d;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ready_c && i_valid) begin
            r_smooth_c <= n_smooth_c;
        end
        if (w_ready_d && r_valid_c) begin
            r_level_d <= n_level_d;
        end
        if (w_ready_e && r_valid_d) begin
            r_level_e <= r_level_d;
            r_tile_e  <= n_tile_e;
        end
    end

    assign o_ready       = w_ready_c;
    assign o_valid       = r_valid_e;
    assign o_tile_code   = r_tile_e;
    assign o_noise_level = r_level_e;

`ifndef ASSERT_OFF
    a_level_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid_e |-> (r_level_e <= vntc_pkg::LEVEL_MAX))
        else $error("noise level above smoothing maximum");
`endif

endmodule

`default_nettype wire

FILE: design/value_noise_terrain_classifier_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Value-noise terrain classifier. Each request (pos_x, pos_y) gives exactly one
// result (tile_code, noise_level), in request order. One request is taken every
// cycle while o_in_stall is low. A request passes through the one-bit-per-stage
// restoring divider that turns coordinates into lattice points, the hash stages
// (xor-shift mix, then the seed product) and the stages for smoothing, averaging
// and classification. Results held by a stalled output do not block requests
// until every stage is full. Registers lie at byte address 4*index; the user
// must write them only while no request is in flight, which the block does not
// enforce. A scale of zero gives lattice point 255 on both axes.
module value_noise_terrain_classifier_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [7:0]  i_pos_x,
    input  wire logic [7:0]  i_pos_y,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [1:0]       o_tile_code,
    output logic [7:0]       o_noise_level,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic [7:0]       r_seed;
    logic [7:0]       r_scale;
    logic [7:0]       r_water_limit;
    logic [7:0]       r_grass_limit;
    logic [7:0]       r_tree_limit;

    logic             w_div_ready;
    logic             w_div_valid;
    vntc_pkg::t_coord w_lattice;
    logic             w_hash_ready;
    logic             w_hash_valid;
    vntc_pkg::t_grid  w_grid;
    logic             w_smooth_ready;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed        <= vntc_pkg::SEED_RESET;
            r_scale       <= vntc_pkg::SCALE_RESET;
            r_water_limit <= vntc_pkg::WATER_RESET;
            r_grass_limit <= vntc_pkg::GRASS_RESET;
            r_tree_limit  <= vntc_pkg::TREE_RESET;
        end else if (psel && penable && pwrite && pready) begin
            case (paddr[4:2])
                vntc_pkg::REG_SEED:  r_seed        <= pwdata[7:0];
                vntc_pkg::REG_SCALE: r_scale       <= pwdata[7:0];
                vntc_pkg::REG_WATER: r_water_limit <= pwdata[7:0];
                vntc_pkg::REG_GRASS: r_grass_limit <= pwdata[7:0];
                vntc_pkg::REG_TREE:  r_tree_limit  <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            vntc_pkg::REG_SEED:  prdata = {24'd0, r_seed};
            vntc_pkg::REG_SCALE: prdata = {24'd0, r_scale};
            vntc_pkg::REG_WATER: prdata = {24'd0, r_water_limit};
            vntc_pkg::REG_GRASS: prdata = {24'd0, r_grass_limit};
            vntc_pkg::REG_TREE:  prdata = {24'd0, r_tree_limit};
            default:             prdata = '0;
        endcase
    end

    vntc_div_pipe u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (w_div_ready),
        .i_num_x (i_pos_x),
        .i_num_y (i_pos_y),
        .i_den   (r_scale),
        .o_valid (w_div_valid),
        .i_ready (w_hash_ready),
        .o_quo   (w_lattice)
    );

    vntc_hash u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_div_valid),
        .o_ready (w_hash_ready),
        .i_coord (w_lattice),
        .i_seed  (r_seed),
        .o_valid (w_hash_valid),
        .i_ready (w_smooth_ready),
        .o_grid  (w_grid)
    );

    vntc_smooth u_smooth (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (w_hash_valid),
        .o_ready       (w_smooth_ready),
        .i_grid        (w_grid),
        .i_water_limit (r_water_limit),
        .i_grass_limit (r_grass_limit),
        .i_tree_limit  (r_tree_limit),
        .o_valid       (o_out_valid),
        .i_ready       (!i_out_stall),
        .o_tile_code   (o_tile_code),
        .o_noise_level (o_noise_level)
    );

    assign o_in_stall = !w_div_ready;

`ifndef ASSERT_OFF
    a_stall_from_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("request stalled while output side is free");

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");
`endif

endmodule

`default_nettype wire
